// ===== design/amrb_pkg.sv =====
// Shared types and constants for the audio mixing ring buffer.
package amrb_pkg;

    localparam int SAMPLE_W = 16;
    localparam int RING_REG_W = 8;
    localparam int BASE_W = 7;
    localparam int OFFSET_W = 16;
    localparam int POS_W = 9;
    // base_slot + frame_offset needs one bit more than the offset
    localparam int DVD_W = OFFSET_W + 1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SAMPLE_W:0] t_sum;

    localparam logic [RING_REG_W-1:0] RING_FRAMES_RST = 8'd100;

    localparam logic OP_MIX = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam t_sum SUM_MAX = 17'sd32767;
    localparam t_sum SUM_MIN = -17'sd32768;

endpackage

// ===== design/audio_mixing_ring_buffer_unit.sv =====
// Audio mixing ring buffer: frame ring in one RAM, mix and read-and-clear beats.
//
// The ring holds MAX_FRAMES frames of FRAME_SAMPLES signed 16-bit samples in one
// single-port synchronous RAM. After reset the block sweeps all MAX_FRAMES *
// FRAME_SAMPLES entries (61440 at the defaults) to zero, one entry per cycle;
// no beat is accepted during the sweep, ring_frames writes are taken at any time.
// A mix beat reduces base_slot + frame_offset modulo the ring size with a
// one-bit-per-cycle remainder unit, forms the address, then reads, averages and
// writes back the entry. A mix with an out-of-frame sample position skips the
// RAM, and a read beat skips the remainder unit. The result sits in an output
// register, so the next beat is taken while it waits.
module audio_mixing_ring_buffer_unit
    import amrb_pkg::*;
#(
    parameter int FRAME_SAMPLES = 480,
    parameter int MAX_FRAMES = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // ring size register
    input  logic                  i_cfg_we,
    input  logic [RING_REG_W-1:0] i_cfg_wdata,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_opcode,
    input  logic [BASE_W-1:0]     i_base_slot,
    input  logic [OFFSET_W-1:0]   i_frame_offset,
    input  logic [POS_W-1:0]      i_sample_pos,
    input  t_sample               i_sample_in,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_sample               o_sample_out,
    output logic                  o_frame_done
);

    localparam int DEPTH = MAX_FRAMES * FRAME_SAMPLES;
    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(MAX_FRAMES);
    localparam int SW = $clog2(FRAME_SAMPLES + 1);
    localparam int CMP_W = (FW + 1 > RING_REG_W + 1) ? FW + 1 : RING_REG_W + 1;
    localparam int PW = (SW > POS_W) ? SW + 1 : POS_W + 1;
    localparam int CNT_W = $clog2(DVD_W + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_ADDR = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    // control state
    logic [2:0]            r_state, n_state;
    logic                  r_clearing;
    logic [AW-1:0]         r_clr_addr;
    logic [RING_REG_W-1:0] r_ring_frames;
    logic [FW-1:0]         r_read_frame, n_read_frame;
    logic [SW-1:0]         r_read_sample, n_read_sample;
    logic                  r_out_valid, n_out_valid;
    logic [CNT_W-1:0]      r_cnt, n_cnt;

    // item payload
    logic                  r_op;
    logic [POS_W-1:0]      r_pos;
    t_sample               r_new;
    logic [DVD_W-1:0]      r_dvd, n_dvd;
    logic [CMP_W-1:0]      r_rem, n_rem;
    logic [AW-1:0]         r_addr, n_addr;
    logic                  r_skip, n_skip;
    t_sample               r_rdata;
    t_sample               r_result, n_result;
    logic                  r_done, n_done;
    t_sample               r_sample_out;
    logic                  r_frame_done;

    // memory
    logic [SAMPLE_W-1:0]   r_mem [DEPTH];
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [SAMPLE_W-1:0]   mem_wdata;

    logic                  in_beat;
    logic                  out_free;
    logic [CMP_W-1:0]      eff_rf;
    logic [CMP_W-1:0]      rem_shift;
    logic [CMP_W-1:0]      frame_next;
    logic [PW-1:0]         sample_next;
    t_sum                  mix_sum;
    t_sum                  mix_half;
    t_sum                  mix_sat;

    assign in_beat  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign o_in_ready   = (r_state == S_IDLE) && !r_clearing;
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_frame_done = r_frame_done;

    // Clamp the ring size register to 1..MAX_FRAMES
    always_comb begin
        eff_rf = CMP_W'(r_ring_frames);
        if (r_ring_frames == '0) begin
            eff_rf = CMP_W'(1);
        end
        if (eff_rf > CMP_W'(MAX_FRAMES)) begin
            eff_rf = CMP_W'(MAX_FRAMES);
        end
    end

    // Average with truncation toward zero (a zero entry takes the new sample as is), then saturate
    always_comb begin
        mix_sum = t_sum'(r_rdata) + t_sum'(r_new);
        if (r_rdata != '0) begin
            mix_half = (mix_sum + t_sum'({1'b0, mix_sum[SAMPLE_W]})) >>> 1;
        end else begin
            mix_half = mix_sum;
        end
        if (mix_half > SUM_MAX) begin
            mix_sat = SUM_MAX;
        end else if (mix_half < SUM_MIN) begin
            mix_sat = SUM_MIN;
        end else begin
            mix_sat = mix_half;
        end
    end

    assign rem_shift   = {r_rem[CMP_W-2:0], r_dvd[DVD_W-1]};
    assign frame_next  = CMP_W'(r_read_frame) + CMP_W'(1);
    assign sample_next = PW'(r_read_sample) + PW'(1);

    // Sequencer: remainder, address, read, write back, hand off result
    always_comb begin
        n_state       = r_state;
        n_read_frame  = r_read_frame;
        n_read_sample = r_read_sample;
        n_out_valid   = r_out_valid;
        n_cnt         = r_cnt;
        n_dvd         = r_dvd;
        n_rem         = r_rem;
        n_addr        = r_addr;
        n_skip        = r_skip;
        n_result      = r_result;
        n_done        = r_done;
        mem_we        = 1'b0;
        mem_waddr     = r_addr;
        mem_wdata     = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_dvd = DVD_W'(i_frame_offset) + DVD_W'(i_base_slot);
                    n_rem = '0;
                    n_cnt = '0;
                    n_state = (i_opcode == OP_MIX) ? S_MOD : S_ADDR;
                end
            end
            S_MOD: begin
                // one quotient bit per cycle
                if (rem_shift >= eff_rf) begin
                    n_rem = rem_shift - eff_rf;
                end else begin
                    n_rem = rem_shift;
                end
                n_dvd = {r_dvd[DVD_W-2:0], 1'b0};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                n_done = 1'b0;
                if (r_op == OP_MIX) begin
                    n_addr = AW'(r_rem[FW-1:0]) * AW'(FRAME_SAMPLES) + AW'(r_pos);
                    n_skip = (PW'(r_pos) >= PW'(FRAME_SAMPLES));
                    if (n_skip) begin
                        n_result = '0;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_RD;
                    end
                end else begin
                    // restart the read position if it fell outside the ring
                    if (CMP_W'(r_read_frame) >= eff_rf) begin
                        n_read_frame = '0;
                    end
                    if (PW'(r_read_sample) >= PW'(FRAME_SAMPLES)) begin
                        n_read_sample = '0;
                    end
                    n_addr = AW'(n_read_frame) * AW'(FRAME_SAMPLES) + AW'(n_read_sample);
                    n_skip = 1'b0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_WB;
            end
            S_WB: begin
                mem_we = 1'b1;
                if (r_op == OP_MIX) begin
                    n_result  = mix_sat[SAMPLE_W-1:0];
                    mem_wdata = mix_sat[SAMPLE_W-1:0];
                end else begin
                    n_result  = r_rdata;
                    mem_wdata = '0;
                    // advance the read position
                    if (sample_next >= PW'(FRAME_SAMPLES)) begin
                        n_read_sample = '0;
                        n_done = 1'b1;
                        if (frame_next >= eff_rf) begin
                            n_read_frame = '0;
                        end else begin
                            n_read_frame = frame_next[FW-1:0];
                        end
                    end else begin
                        n_read_sample = sample_next[SW-1:0];
                    end
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_clearing    <= 1'b1;
            r_clr_addr    <= '0;
            r_ring_frames <= RING_FRAMES_RST;
            r_read_frame  <= '0;
            r_read_sample <= '0;
            r_out_valid   <= 1'b0;
            r_cnt         <= '0;
        end else begin
            r_state       <= n_state;
            r_read_frame  <= n_read_frame;
            r_read_sample <= n_read_sample;
            r_out_valid   <= n_out_valid;
            r_cnt         <= n_cnt;
            if (i_cfg_we) begin
                r_ring_frames <= i_cfg_wdata;
            end
            // sweep the RAM to zero after reset
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_op  <= i_opcode;
            r_pos <= i_sample_pos;
            r_new <= i_sample_in;
        end
        r_dvd    <= n_dvd;
        r_rem    <= n_rem;
        r_addr   <= n_addr;
        r_skip   <= n_skip;
        r_result <= n_result;
        r_done   <= n_done;
        if (r_state == S_OUT && out_free) begin
            r_sample_out <= r_result;
            r_frame_done <= r_done && !r_skip;
        end
    end

    // Ring RAM: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (r_state == S_RD) begin
            r_rdata <= r_mem[r_addr];
        end
    end

endmodule
